// ===== sv/double_ended_queue_unit_macros.svh =====
// Assertion macros shared by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// Shared types and codes of the double-ended queue.
`default_nettype none
package deq_pkg;

	// Request kinds
	typedef enum logic [1:0] {
		KIND_PUSH_FRONT  = 2'd0,
		KIND_POP_FRONT   = 2'd1,
		KIND_INJECT_REAR = 2'd2,
		KIND_EJECT_REAR  = 2'd3
	} kind_t;

	// Result status codes; the fourth code is never produced
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_RESERVED = 2'd3;

	// Memory access and outcome decided for one request
	typedef struct packed {
		logic       rd_en;
		logic       wr_en;
		logic [1:0] status;
	} deq_op_t;

endpackage
`default_nettype wire

// ===== sv/deq_ptr.sv =====
// Front index and entry count of the ring, with address and outcome per request.
`default_nettype none
module deq_ptr import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire logic [1:0]               kind,
	output logic      [$clog2(DEPTH)-1:0] addr,
	output deq_op_t                       op
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;

	logic          full;
	logic          empty;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW:0]   sum;
	logic [AW:0]   sum_m1;
	logic [AW-1:0] rear_slot;
	logic [AW-1:0] last_slot;
	logic [AW-1:0] front_nxt;
	logic [CW-1:0] count_nxt;

	// Wrapped neighbor positions of the front and the rear
	always_comb begin
		full      = (count_q == FULL_CNT);
		empty     = (count_q == '0);
		front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
		front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
		sum       = {1'b0, front_q} + (AW + 1)'(count_q);
		sum_m1    = sum - (AW + 1)'(1);
		rear_slot = (sum >= DEPTH_W) ? AW'(sum - DEPTH_W) : sum[AW-1:0];
		last_slot = (sum_m1 >= DEPTH_W) ? AW'(sum_m1 - DEPTH_W) : sum_m1[AW-1:0];
	end

	// Decode the request into an access, a status and the next pointers
	always_comb begin
		addr      = front_q;
		op        = '{rd_en: 1'b0, wr_en: 1'b0, status: ST_DONE};
		front_nxt = front_q;
		count_nxt = count_q;
		case (kind_t'(kind))
			KIND_PUSH_FRONT: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					addr      = front_dec;
					op.wr_en  = 1'b1;
					front_nxt = front_dec;
					count_nxt = count_q + CW'(1);
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					addr      = front_q;
					op.rd_en  = 1'b1;
					front_nxt = front_inc;
					count_nxt = count_q - CW'(1);
				end
			end
			KIND_INJECT_REAR: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					addr      = rear_slot;
					op.wr_en  = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			KIND_EJECT_REAR: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					addr      = last_slot;
					op.rd_en  = 1'b1;
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
				op.status = ST_DONE;
			end
		endcase
	end

	// Advance the pointers on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== sv/double_ended_queue_unit.sv =====
// Bounded double-ended queue: one request in, one result out, ring held in a memory.
//
// The unit takes one request per clock cycle (push front, pop front, inject
// rear, eject rear) and returns exactly one result per request, in order. Index
// and count updates finish in the cycle of the input transfer, and the ring
// memory is written or read in that same cycle; a removed word comes out of the
// memory's registered read port into the stage-one register and then into the
// output register, which offers the result. The one read port and the two
// result registers set the rate: with the output side taking every result, a
// new request is accepted in every cycle. Inserting into a full ring reports
// full, removing from an empty ring reports empty and returns zero. Ring
// contents need no clearing after reset.
`default_nettype none
module double_ended_queue_unit import deq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((DATA_WIDTH + 7) / 8)*8-1:0] s_tdata,  // [DATA_WIDTH-1:0] value
	input  wire logic [1:0]                          s_tuser,  // [1:0] kind
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [((DATA_WIDTH + 7) / 8)*8-1:0] m_tdata,  // [DATA_WIDTH-1:0] taken_value
	output logic      [1:0]                          m_tuser   // [1:0] status
);

	localparam int AW = $clog2(DEPTH);
	localparam int TW = ((DATA_WIDTH + 7) / 8) * 8;

	logic          accept;
	logic          load_out;
	logic [AW-1:0] addr;
	deq_op_t       op;

	logic [DATA_WIDTH-1:0] ring_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_s1;
	logic                  valid_s1;
	logic                  from_mem_s1;
	logic [1:0]            status_s1;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic [1:0]            out_status_q;

	assign accept   = s_tvalid && s_tready;
	assign load_out = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || load_out;

	deq_ptr #(
		.DEPTH (DEPTH)
	) u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (s_tuser),
		.addr   (addr),
		.op     (op)
	);

	// Ring memory: one write or one registered read per transfer
	always_ff @(posedge clk) begin
		if (accept && op.wr_en) begin
			ring_q[addr] <= s_tdata[DATA_WIDTH-1:0];
		end
		if (accept && op.rd_en) begin
			rdata_s1 <= ring_q[addr];
		end
	end

	// Hold the outcome while the read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_mem_s1 <= op.rd_en;
			status_s1   <= op.status;
		end
	end

	// Output register: load from stage one, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q   <= from_mem_s1 ? rdata_s1 : '0;
			out_status_q <= status_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TW'(out_data_q);
	assign m_tuser  = out_status_q;

endmodule
`default_nettype wire

// ===== sv/deq_chk.sv =====
// Port-level checker of the double-ended queue and its bind.
`default_nettype none
`include "double_ended_queue_unit_macros.svh"
module deq_chk import deq_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tvalid,
	input wire logic                                s_tready,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [((DATA_WIDTH + 7) / 8)*8-1:0] m_tdata,
	input wire logic [1:0]                          m_tuser
);

	// Stalled result holds
	`DEQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// Status never takes the unused code
	`DEQ_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tuser != ST_RESERVED, "reserved status code")

	// Refused requests return zero
	`DEQ_ASSERT_NOW(a_refused_zero, clk, arst_n, m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY), m_tdata == '0, "refused request returned data")

	// A result never shows up without a pending request transfer
	`DEQ_ASSERT_NEXT(a_no_early_result, clk, arst_n, !m_tvalid && !(s_tvalid && s_tready) && !$past(s_tvalid && s_tready), !m_tvalid, "result without a pending request")

endmodule

bind double_ended_queue_unit deq_chk #(
	.DATA_WIDTH (DATA_WIDTH)
) u_deq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
